// ----- design/tlca_pkg.sv -----
package tlca_pkg;

   localparam int NODE_W = 11;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      KIND_EDGE  = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_ID     = 2'd1,
      STAT_INCOMPLETE = 2'd2,
      STAT_UNREACHED  = 2'd3
   } status_type;

   // register index, taken from paddr[2]
   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic REG_ROOT_NODE  = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_BUILD_START,
      OP_CLR_MARK,
      OP_INIT_ROOT,
      OP_POP,
      OP_POP_LATCH,
      OP_EDGE_READ,
      OP_MARK_READ,
      OP_VISIT,
      OP_LVL_INIT,
      OP_LVL_READ1,
      OP_LVL_READ2,
      OP_LVL_WRITE,
      OP_BUILT,
      OP_DEPTH_A,
      OP_DEPTH_B,
      OP_ORDER,
      OP_UP_READ,
      OP_UP_SKIP,
      OP_UP_LATCH,
      OP_DOWN_INIT,
      OP_DU_READ,
      OP_DV_READ,
      OP_DCMP,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic bad_id;
      logic too_few;
      logic built;
      logic all_reached;
      logic clr_last;
      logic queue_empty;
      logic scan_done;
      logic edge_hit;
      logic marked;
      logic lvl_done;
      logic diff_bit;
      logic u_eq_v;
      logic k_zero;
   } dp_stat_type;

endpackage

// ----- design/tlca_ctrl.sv -----
module tlca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  tlca_pkg::kind_type    req_kind,
   input  logic                  out_free,
   input  tlca_pkg::dp_stat_type stat,
   output tlca_pkg::op_type      op,
   output logic                  req_ready,
   output logic                  res_load,
   output tlca_pkg::status_type  res_status
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_CLR, S_INIT, S_POP, S_POPW, S_SCAN, S_EMATCH, S_MCHK,
      S_LVL_INIT, S_LVL_CHK, S_LREAD2, S_LWRITE, S_BUILT, S_REACH, S_QD2, S_QD3,
      S_UP, S_UPW, S_EQ, S_DU, S_DV, S_DCMP, S_FIN0, S_FIN1, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   tlca_pkg::status_type code_ff, code_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign res_load   = (state_ff == S_DONE) && out_free;
   assign res_status = code_ff;

   // sequence the request checks, the build walk, the level fill and the lifting
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      op       = tlca_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = tlca_pkg::OP_ACCEPT;
               if (req_kind == tlca_pkg::KIND_QUERY) state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.bad_id) begin
               code_in  = tlca_pkg::STAT_BAD_ID;
               state_in = S_DONE;
            end else if (stat.too_few) begin
               code_in  = tlca_pkg::STAT_INCOMPLETE;
               state_in = S_DONE;
            end else if (!stat.built) begin
               op       = tlca_pkg::OP_BUILD_START;
               state_in = S_CLR;
            end else begin
               state_in = S_REACH;
            end
         end
         S_CLR: begin
            op = tlca_pkg::OP_CLR_MARK;
            if (stat.clr_last) state_in = S_INIT;
         end
         S_INIT: begin
            op       = tlca_pkg::OP_INIT_ROOT;
            state_in = S_POP;
         end
         S_POP: begin
            if (stat.queue_empty) begin
               state_in = S_LVL_INIT;
            end else begin
               op       = tlca_pkg::OP_POP;
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            op       = tlca_pkg::OP_POP_LATCH;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_POP;
            end else begin
               op       = tlca_pkg::OP_EDGE_READ;
               state_in = S_EMATCH;
            end
         end
         S_EMATCH: begin
            if (stat.edge_hit) begin
               op       = tlca_pkg::OP_MARK_READ;
               state_in = S_MCHK;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_MCHK: begin
            if (!stat.marked) op = tlca_pkg::OP_VISIT;
            state_in = S_SCAN;
         end
         S_LVL_INIT: begin
            op       = tlca_pkg::OP_LVL_INIT;
            state_in = S_LVL_CHK;
         end
         S_LVL_CHK: begin
            if (stat.lvl_done) begin
               state_in = S_BUILT;
            end else begin
               op       = tlca_pkg::OP_LVL_READ1;
               state_in = S_LREAD2;
            end
         end
         S_LREAD2: begin
            op       = tlca_pkg::OP_LVL_READ2;
            state_in = S_LWRITE;
         end
         S_LWRITE: begin
            op       = tlca_pkg::OP_LVL_WRITE;
            state_in = S_LVL_CHK;
         end
         S_BUILT: begin
            op       = tlca_pkg::OP_BUILT;
            state_in = S_REACH;
         end
         S_REACH: begin
            if (!stat.all_reached) begin
               code_in  = tlca_pkg::STAT_UNREACHED;
               state_in = S_DONE;
            end else begin
               op       = tlca_pkg::OP_DEPTH_A;
               state_in = S_QD2;
            end
         end
         S_QD2: begin
            op       = tlca_pkg::OP_DEPTH_B;
            state_in = S_QD3;
         end
         S_QD3: begin
            op       = tlca_pkg::OP_ORDER;
            state_in = S_UP;
         end
         S_UP: begin
            if (stat.lvl_done) begin
               state_in = S_EQ;
            end else if (stat.diff_bit) begin
               op       = tlca_pkg::OP_UP_READ;
               state_in = S_UPW;
            end else begin
               op = tlca_pkg::OP_UP_SKIP;
            end
         end
         S_UPW: begin
            op       = tlca_pkg::OP_UP_LATCH;
            state_in = S_UP;
         end
         S_EQ: begin
            if (stat.u_eq_v) begin
               code_in  = tlca_pkg::STAT_OK;
               state_in = S_DONE;
            end else begin
               op       = tlca_pkg::OP_DOWN_INIT;
               state_in = S_DU;
            end
         end
         S_DU: begin
            op       = tlca_pkg::OP_DU_READ;
            state_in = S_DV;
         end
         S_DV: begin
            op       = tlca_pkg::OP_DV_READ;
            state_in = S_DCMP;
         end
         S_DCMP: begin
            op       = tlca_pkg::OP_DCMP;
            state_in = stat.k_zero ? S_FIN0 : S_DU;
         end
         S_FIN0: begin
            op       = tlca_pkg::OP_DU_READ;
            state_in = S_FIN1;
         end
         S_FIN1: begin
            op       = tlca_pkg::OP_FINISH;
            code_in  = tlca_pkg::STAT_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= tlca_pkg::STAT_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ----- design/tlca_dpath.sv -----
module tlca_dpath #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tlca_pkg::op_type             op,
   input  tlca_pkg::kind_type           req_kind,
   input  logic [tlca_pkg::NODE_W-1:0]  req_a,
   input  logic [tlca_pkg::NODE_W-1:0]  req_b,
   input  logic [tlca_pkg::NODE_W-1:0]  node_count,
   input  logic [tlca_pkg::NODE_W-1:0]  root_node,
   input  logic                         cfg_write,
   output tlca_pkg::dp_stat_type        stat,
   output logic [tlca_pkg::NODE_W-1:0]  answer
);

   localparam int NW   = tlca_pkg::NODE_W;
   localparam int NIW  = $clog2(MAX_NODES);
   localparam int DW   = NIW;
   localparam int QW   = $clog2(MAX_NODES + 1);
   localparam int ETW  = $clog2(MAX_NODES);
   localparam int EIW  = (MAX_NODES > 2) ? $clog2(MAX_NODES - 1) : 1;
   localparam int KW   = $clog2(LIFT_LEVELS + 1);
   localparam int LIW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int EDGES = MAX_NODES - 1;

   // memories
   logic [NW-1:0]      edge_a_mem [EDGES];
   logic [NW-1:0]      edge_b_mem [EDGES];
   logic [NW+DW-1:0]   queue_mem  [MAX_NODES];
   logic               mark_mem   [MAX_NODES];
   logic [DW-1:0]      depth_mem  [MAX_NODES];
   logic [NW-1:0]      anc_mem    [LIFT_LEVELS][MAX_NODES];

   // control registers
   logic [ETW-1:0] edge_total_ff;
   logic           built_ff;
   logic           reached_ff;

   // walk and query registers
   logic [NW-1:0]    u_ff, v_ff, x_ff, y_ff, pu_ff;
   logic [DW-1:0]    dx_ff, du_ff, diff_ff;
   logic [NIW-1:0]   i_ff;
   logic [KW-1:0]    k_ff;
   logic [QW-1:0]    head_ff, tail_ff;
   logic [ETW-1:0]   e_ff;

   // read data
   logic [NW-1:0]    ea_rd_ff, eb_rd_ff, anc_rd_ff;
   logic             anc_zero_ff;
   logic [NW+DW-1:0] q_rd_ff;
   logic             mark_rd_ff;
   logic [DW-1:0]    depth_rd_ff;

   logic [NW-1:0]  cnt;
   logic [NW-1:0]  anc_val;
   logic [NW-1:0]  y_sel;
   logic           y_match;
   logic           edge_ok;
   logic           a_bad, b_bad, r_bad;
   logic [DW-1:0]  dx_next;

   // ancestor memory ports
   logic            anc_re, anc_we;
   logic [LIW-1:0]  anc_rl, anc_wl;
   logic [NW-1:0]   anc_rn;
   logic [NIW-1:0]  anc_wi;
   logic [NW-1:0]   anc_wd;

   // depth, mark and queue write ports
   logic            mark_we, mark_wd;
   logic [NIW-1:0]  mark_wi;
   logic            depth_we;
   logic [NIW-1:0]  depth_wi;
   logic [DW-1:0]   depth_wd;
   logic            q_we;
   logic [NIW-1:0]  q_wi;
   logic [NW+DW-1:0] q_wd;

   // clamp the node count into 1..MAX_NODES
   always_comb begin
      if (node_count == '0) cnt = NW'(1);
      else if (32'(node_count) > 32'(MAX_NODES)) cnt = NW'(MAX_NODES);
      else cnt = node_count;
   end

   assign anc_val = anc_zero_ff ? '0 : anc_rd_ff;
   assign dx_next = dx_ff + DW'(1);
   assign answer  = u_ff;

   assign a_bad   = (req_a == '0) || (req_a > cnt);
   assign b_bad   = (req_b == '0) || (req_b > cnt);
   assign r_bad   = (root_node == '0) || (root_node > cnt);
   assign edge_ok = !a_bad && !b_bad
                    && (32'(edge_total_ff) < 32'(cnt) - 32'd1)
                    && (32'(edge_total_ff) < 32'(MAX_NODES) - 32'd1);

   // pick the far end of the edge under scan
   always_comb begin
      y_match = 1'b1;
      if (ea_rd_ff == x_ff) y_sel = eb_rd_ff;
      else if (eb_rd_ff == x_ff) y_sel = ea_rd_ff;
      else begin
         y_sel   = '0;
         y_match = 1'b0;
      end
   end

   always_comb begin
      stat.bad_id      = (u_ff == '0) || (u_ff > cnt) || (v_ff == '0) || (v_ff > cnt) || r_bad;
      stat.too_few     = 32'(edge_total_ff) < 32'(cnt) - 32'd1;
      stat.built       = built_ff;
      stat.all_reached = reached_ff;
      stat.clr_last    = 32'(i_ff) == 32'(cnt) - 32'd1;
      stat.queue_empty = head_ff == tail_ff;
      stat.scan_done   = e_ff == edge_total_ff;
      stat.edge_hit    = y_match && (y_sel != '0) && (y_sel <= cnt);
      stat.marked      = mark_rd_ff;
      stat.lvl_done    = 32'(k_ff) == 32'(LIFT_LEVELS);
      stat.diff_bit    = diff_ff[0];
      stat.u_eq_v      = u_ff == v_ff;
      stat.k_zero      = k_ff == '0;
   end

   // route addresses to the memory ports
   always_comb begin
      anc_re   = 1'b0;
      anc_rl   = LIW'(k_ff);
      anc_rn   = u_ff;
      anc_we   = 1'b0;
      anc_wl   = '0;
      anc_wi   = NIW'(y_ff - NW'(1));
      anc_wd   = x_ff;
      mark_we  = 1'b0;
      mark_wd  = 1'b0;
      mark_wi  = i_ff;
      depth_we = 1'b0;
      depth_wi = NIW'(y_ff - NW'(1));
      depth_wd = dx_next;
      q_we     = 1'b0;
      q_wi     = NIW'(tail_ff);
      q_wd     = {dx_next, y_ff};
      case (op)
         tlca_pkg::OP_CLR_MARK: begin
            mark_we = 1'b1;
         end
         tlca_pkg::OP_INIT_ROOT: begin
            mark_we  = 1'b1;
            mark_wd  = 1'b1;
            mark_wi  = NIW'(root_node - NW'(1));
            depth_we = 1'b1;
            depth_wi = NIW'(root_node - NW'(1));
            depth_wd = '0;
            anc_we   = 1'b1;
            anc_wi   = NIW'(root_node - NW'(1));
            anc_wd   = '0;
            q_we     = 1'b1;
            q_wi     = '0;
            q_wd     = {{DW{1'b0}}, root_node};
         end
         tlca_pkg::OP_VISIT: begin
            mark_we  = 1'b1;
            mark_wd  = 1'b1;
            mark_wi  = NIW'(y_ff - NW'(1));
            depth_we = 1'b1;
            anc_we   = 1'b1;
            q_we     = 32'(tail_ff) < 32'(MAX_NODES);
         end
         tlca_pkg::OP_LVL_READ1: begin
            anc_re = 1'b1;
            anc_rl = LIW'(k_ff - KW'(1));
            anc_rn = NW'(i_ff) + NW'(1);
         end
         tlca_pkg::OP_LVL_READ2: begin
            anc_re = 1'b1;
            anc_rl = LIW'(k_ff - KW'(1));
            anc_rn = anc_val;
         end
         tlca_pkg::OP_LVL_WRITE: begin
            anc_we = 1'b1;
            anc_wl = LIW'(k_ff);
            anc_wi = i_ff;
            anc_wd = anc_val;
         end
         tlca_pkg::OP_UP_READ, tlca_pkg::OP_DU_READ: begin
            anc_re = 1'b1;
         end
         tlca_pkg::OP_DV_READ: begin
            anc_re = 1'b1;
            anc_rn = v_ff;
         end
         default: ;
      endcase
   end

   // edge store
   always_ff @(posedge clock) begin
      if (op == tlca_pkg::OP_ACCEPT && req_kind == tlca_pkg::KIND_EDGE && edge_ok) begin
         edge_a_mem[EIW'(edge_total_ff)] <= req_a;
         edge_b_mem[EIW'(edge_total_ff)] <= req_b;
      end
      if (op == tlca_pkg::OP_EDGE_READ) begin
         ea_rd_ff <= edge_a_mem[EIW'(e_ff)];
         eb_rd_ff <= edge_b_mem[EIW'(e_ff)];
      end
   end

   // walk queue
   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_wi] <= q_wd;
      if (op == tlca_pkg::OP_POP) q_rd_ff <= queue_mem[NIW'(head_ff)];
   end

   // reached marks
   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_wi] <= mark_wd;
      if (op == tlca_pkg::OP_MARK_READ) mark_rd_ff <= mark_mem[NIW'(y_sel - NW'(1))];
   end

   // node depths
   always_ff @(posedge clock) begin
      if (depth_we) depth_mem[depth_wi] <= depth_wd;
      if (op == tlca_pkg::OP_DEPTH_A) depth_rd_ff <= depth_mem[NIW'(u_ff - NW'(1))];
      if (op == tlca_pkg::OP_DEPTH_B) depth_rd_ff <= depth_mem[NIW'(v_ff - NW'(1))];
   end

   // ancestor table; node 0 reads as no ancestor
   always_ff @(posedge clock) begin
      if (anc_we) anc_mem[anc_wl][anc_wi] <= anc_wd;
      if (anc_re) begin
         anc_zero_ff <= anc_rn == '0;
         if (anc_rn != '0) anc_rd_ff <= anc_mem[anc_rl][NIW'(anc_rn - NW'(1))];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         built_ff      <= 1'b0;
         reached_ff    <= 1'b0;
      end else begin
         if (cfg_write) built_ff <= 1'b0;
         if (op == tlca_pkg::OP_ACCEPT) begin
            if (req_kind == tlca_pkg::KIND_EDGE && edge_ok) begin
               edge_total_ff <= edge_total_ff + ETW'(1);
               built_ff      <= 1'b0;
            end
            if (req_kind == tlca_pkg::KIND_CLEAR) begin
               edge_total_ff <= '0;
               built_ff      <= 1'b0;
               reached_ff    <= 1'b0;
            end
         end
         if (op == tlca_pkg::OP_LVL_INIT) reached_ff <= 32'(tail_ff) == 32'(cnt);
         if (op == tlca_pkg::OP_BUILT) built_ff <= 1'b1;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (op)
         tlca_pkg::OP_ACCEPT: begin
            u_ff <= req_a;
            v_ff <= req_b;
         end
         tlca_pkg::OP_BUILD_START: i_ff <= '0;
         tlca_pkg::OP_CLR_MARK: i_ff <= i_ff + NIW'(1);
         tlca_pkg::OP_INIT_ROOT: begin
            head_ff <= '0;
            tail_ff <= QW'(1);
         end
         tlca_pkg::OP_POP: head_ff <= head_ff + QW'(1);
         tlca_pkg::OP_POP_LATCH: begin
            x_ff  <= q_rd_ff[NW-1:0];
            dx_ff <= q_rd_ff[NW+DW-1:NW];
            e_ff  <= '0;
         end
         tlca_pkg::OP_EDGE_READ: e_ff <= e_ff + ETW'(1);
         tlca_pkg::OP_MARK_READ: y_ff <= y_sel;
         tlca_pkg::OP_VISIT: begin
            if (32'(tail_ff) < 32'(MAX_NODES)) tail_ff <= tail_ff + QW'(1);
         end
         tlca_pkg::OP_LVL_INIT: begin
            k_ff <= KW'(1);
            i_ff <= '0;
         end
         tlca_pkg::OP_LVL_WRITE: begin
            if (32'(i_ff) == 32'(cnt) - 32'd1) begin
               i_ff <= '0;
               k_ff <= k_ff + KW'(1);
            end else begin
               i_ff <= i_ff + NIW'(1);
            end
         end
         tlca_pkg::OP_DEPTH_B: du_ff <= depth_rd_ff;
         tlca_pkg::OP_ORDER: begin
            k_ff <= '0;
            if (du_ff < depth_rd_ff) begin
               u_ff    <= v_ff;
               v_ff    <= u_ff;
               diff_ff <= depth_rd_ff - du_ff;
            end else begin
               diff_ff <= du_ff - depth_rd_ff;
            end
         end
         tlca_pkg::OP_UP_SKIP: begin
            diff_ff <= diff_ff >> 1;
            k_ff    <= k_ff + KW'(1);
         end
         tlca_pkg::OP_UP_LATCH: begin
            u_ff    <= anc_val;
            diff_ff <= diff_ff >> 1;
            k_ff    <= k_ff + KW'(1);
         end
         tlca_pkg::OP_DOWN_INIT: k_ff <= KW'(LIFT_LEVELS - 1);
         tlca_pkg::OP_DV_READ: pu_ff <= anc_val;
         tlca_pkg::OP_DCMP: begin
            if (pu_ff != anc_val) begin
               u_ff <= pu_ff;
               v_ff <= anc_val;
            end
            if (k_ff != '0) k_ff <= k_ff - KW'(1);
         end
         tlca_pkg::OP_FINISH: u_ff <= anc_val;
         default: ;
      endcase
   end

endmodule

// ----- design/tree_lca_binary_lifting_core.sv -----
// Edge, clear and no-op items are taken in the idle state; they give no result. A query
// with built tables lifts the deeper node up, one ancestor table read per set bit of the
// depth difference, then lifts both nodes down, two ancestor table reads per level. The
// first query after a change clears one mark per node (one per cycle), walks the tree from
// the root, reading all stored edges per queued node, and fills the higher table levels,
// two reads and a write per entry. Synchronous reset clears control state and edge count.
module tree_lca_binary_lifting_core #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // node_a[10:0], node_b[21:11]
   input  logic [1:0]                    req_tuser,   // kind[1:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // ancestor[10:0]
   output logic [1:0]                    rsp_tuser,   // status[1:0]
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tlca_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tlca_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tlca_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int NW = tlca_pkg::NODE_W;

   logic [NW-1:0]         node_count_ff, root_node_ff;
   logic                  cfg_write;
   tlca_pkg::op_type      op;
   tlca_pkg::dp_stat_type stat;
   tlca_pkg::status_type  res_status;
   tlca_pkg::kind_type    req_kind;
   logic                  res_load;
   logic                  req_ready;
   logic                  out_free;
   logic [NW-1:0]         answer;
   logic                  rsp_valid_ff;
   logic [NW-1:0]         rsp_anc_ff;
   logic [1:0]            rsp_stat_ff;

   assign req_kind   = tlca_pkg::kind_type'(req_tuser);
   assign req_tready = req_ready;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NW'(1);
         root_node_ff  <= NW'(1);
      end else if (cfg_write) begin
         unique case (csr_paddr[2])
            tlca_pkg::REG_NODE_COUNT: node_count_ff <= csr_pwdata[NW-1:0];
            tlca_pkg::REG_ROOT_NODE:  root_node_ff  <= csr_pwdata[NW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         tlca_pkg::REG_NODE_COUNT: csr_prdata = {{(tlca_pkg::CSR_DW-NW){1'b0}}, node_count_ff};
         tlca_pkg::REG_ROOT_NODE:  csr_prdata = {{(tlca_pkg::CSR_DW-NW){1'b0}}, root_node_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   tlca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_kind   (req_kind),
      .out_free   (out_free),
      .stat       (stat),
      .op         (op),
      .req_ready  (req_ready),
      .res_load   (res_load),
      .res_status (res_status)
   );

   tlca_dpath #(
      .MAX_NODES   (MAX_NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .req_kind   (req_kind),
      .req_a      (req_tdata[NW-1:0]),
      .req_b      (req_tdata[2*NW-1:NW]),
      .node_count (node_count_ff),
      .root_node  (root_node_ff),
      .cfg_write  (cfg_write),
      .stat       (stat),
      .answer     (answer)
   );

   // result register: hold until transfer
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_anc_ff  <= (res_status == tlca_pkg::STAT_OK) ? answer : '0;
         rsp_stat_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-NW){1'b0}}, rsp_anc_ff};
   assign rsp_tuser  = rsp_stat_ff;

endmodule

// ----- verif/tlca_checker.sv -----
module tlca_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // node_a[10:0], node_b[21:11]
   input  logic [1:0]                  req_tuser,   // kind[1:0]
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [15:0]                 rsp_tdata,   // ancestor[10:0]
   input  logic [1:0]                  rsp_tuser,   // status[1:0]
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tlca_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tlca_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_W = tlca_pkg::NODE_W;
   localparam int NODES  = 1024;
   localparam int LEVELS = 10;

   typedef struct packed {
      logic [NODE_W-1:0]    ancestor;
      tlca_pkg::status_type status;
   } lca_result_t;

   lca_result_t lca_expected[$];

   int unsigned       node_count_q;
   int unsigned       root_q;
   int unsigned       edge_total;
   logic [NODE_W-1:0] edge_a [0:NODES-1];
   logic [NODE_W-1:0] edge_b [0:NODES-1];
   int unsigned       depth_of [0:NODES];
   int unsigned       lift_tab [0:NODES][0:LEVELS-1];
   bit                tables_built;
   bit                all_reached;

   assign pending = lca_expected.size();

   function automatic int unsigned usable_count();
      if (node_count_q < 1) return 1;
      if (node_count_q > NODES) return NODES;
      return node_count_q;
   endfunction

   function automatic int unsigned lift_of(int unsigned node, int unsigned k);
      if (node > NODES || k >= LEVELS) return 0;
      return lift_tab[node][k];
   endfunction

   // breadth-first walk from the root, then fill the doubling levels
   function automatic void build_tables(int unsigned cnt);
      int unsigned walk[$];
      int unsigned head;
      int unsigned x;
      int unsigned y;
      bit          seen [0:NODES];
      for (int i = 0; i <= NODES; i++) begin
         seen[i] = 0;
         depth_of[i] = 0;
         for (int k = 0; k < LEVELS; k++) lift_tab[i][k] = 0;
      end
      seen[root_q] = 1;
      walk = {walk, root_q};
      head = 0;
      while (head < walk.size()) begin
         x = walk[head];
         head++;
         for (int unsigned e = 0; e < edge_total; e++) begin
            if (edge_a[e] == x) y = edge_b[e];
            else if (edge_b[e] == x) y = edge_a[e];
            else continue;
            if (y < 1 || y > cnt || seen[y]) continue;
            seen[y] = 1;
            depth_of[y] = depth_of[x] + 1;
            lift_tab[y][0] = x;
            if (walk.size() < NODES) walk = {walk, y};
         end
      end
      all_reached = (walk.size() == cnt);
      for (int k = 1; k < LEVELS; k++)
         for (int unsigned i = 1; i <= cnt; i++)
            lift_tab[i][k] = lift_of(lift_of(i, k - 1), k - 1);
      tables_built = 1;
   endfunction

   function automatic int unsigned common_ancestor(int unsigned u, int unsigned v);
      int unsigned t;
      int unsigned diff;
      int unsigned pu;
      int unsigned pv;
      if (depth_of[u] < depth_of[v]) begin
         t = u; u = v; v = t;
      end
      diff = depth_of[u] - depth_of[v];
      for (int k = 0; k < LEVELS; k++)
         if (diff[k]) u = lift_of(u, k);
      if (u != v) begin
         for (int k = LEVELS - 1; k >= 0; k--) begin
            pu = lift_of(u, k);
            pv = lift_of(v, k);
            if (pu != pv) begin
               u = pu; v = pv;
            end
         end
         u = lift_of(u, 0);
      end
      return u;
   endfunction

   // advance the tree state by one transfer, queue the answer of a query
   function automatic void apply_item(tlca_pkg::kind_type kind, int unsigned a,
                                      int unsigned b);
      int unsigned cnt;
      lca_result_t r;
      cnt = usable_count();
      case (kind)
         tlca_pkg::KIND_EDGE: begin
            if (a < 1 || a > cnt || b < 1 || b > cnt) return;
            if (edge_total >= cnt - 1 || edge_total >= NODES - 1) return;
            edge_a[edge_total] = NODE_W'(a);
            edge_b[edge_total] = NODE_W'(b);
            edge_total++;
            tables_built = 0;
         end
         tlca_pkg::KIND_CLEAR: begin
            edge_total = 0;
            tables_built = 0;
            all_reached = 0;
         end
         tlca_pkg::KIND_QUERY: begin
            r.ancestor = '0;
            if (a < 1 || a > cnt || b < 1 || b > cnt || root_q < 1 || root_q > cnt)
               r.status = tlca_pkg::STAT_BAD_ID;
            else if (edge_total < cnt - 1)
               r.status = tlca_pkg::STAT_INCOMPLETE;
            else begin
               if (!tables_built) build_tables(cnt);
               if (!all_reached) r.status = tlca_pkg::STAT_UNREACHED;
               else begin
                  r.status = tlca_pkg::STAT_OK;
                  r.ancestor = NODE_W'(common_ancestor(a, b));
               end
            end
            lca_expected = {lca_expected, r};
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      lca_result_t want;
      if (reset) begin
         node_count_q = 1;
         root_q = 1;
         edge_total = 0;
         tables_built = 0;
         all_reached = 0;
         fail_count = 0;
         lca_expected.delete();
      end else begin
         // register write at the access cycle
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == tlca_pkg::REG_NODE_COUNT)
               node_count_q = csr_pwdata[NODE_W-1:0];
            else root_q = csr_pwdata[NODE_W-1:0];
            tables_built = 0;
         end
         // compare a result transfer with the oldest answer
         if (rsp_tvalid && rsp_tready) begin
            if (lca_expected.size() == 0) begin
               $error("unexpected result: ancestor %0d status %0d",
                      rsp_tdata[NODE_W-1:0], rsp_tuser);
               fail_count++;
            end else begin
               want = lca_expected.pop_front();
               if (rsp_tdata[NODE_W-1:0] !== want.ancestor) begin
                  $error("ancestor: expected %0d, actual %0d",
                         want.ancestor, rsp_tdata[NODE_W-1:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_item(tlca_pkg::kind_type'(req_tuser), req_tdata[10:0], req_tdata[21:11]);
      end
   end

endmodule

// ----- verif/tree_lca_binary_lifting_core_tb.sv -----
module tree_lca_binary_lifting_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_GOAL = 1450;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [23:0]                 req_tdata;   // node_a[10:0], node_b[21:11]
   logic [1:0]                  req_tuser;   // kind[1:0]
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [15:0]                 rsp_tdata;   // ancestor[10:0]
   logic [1:0]                  rsp_tuser;   // status[1:0]
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [tlca_pkg::CSR_AW-1:0] csr_paddr;
   logic [tlca_pkg::CSR_DW-1:0] csr_pwdata;
   logic [tlca_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;
   int                          fail_count;
   int                          pending;
   int                          items_sent;
   int                          src_idle;
   int                          dst_idle;

   tree_lca_binary_lifting_core u_top (.*);

   tlca_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Simulation FAILED");
      $finish;
   end

   // result side stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= dst_idle);
   end

   // one input transfer, with random gaps ahead of it
   task automatic send(tlca_pkg::kind_type kind, int unsigned a, int unsigned b);
      if (items_sent < ITEM_GOAL / 3) begin
         src_idle = 26; dst_idle = 47;
      end else if (items_sent < 2 * ITEM_GOAL / 3) begin
         src_idle = 47; dst_idle = 26;
      end else begin
         src_idle = 0; dst_idle = 0;
      end
      while ($urandom_range(99) < src_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, b[10:0], a[10:0]};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // wait until every query has answered and the block is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || !req_tready) @(posedge clock);
   endtask

   // register write once the block has drained
   task automatic csr_write(logic index, int unsigned value);
      drain();
      repeat (20) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic int unsigned pick_node(int unsigned cnt);
      if ($urandom_range(99) < 8) return $urandom_range(2047);
      return $urandom_range(cnt, 1);
   endfunction

   // short directed walk through the corner cases
   task automatic directed_items();
      csr_write(tlca_pkg::REG_NODE_COUNT, 1);
      csr_write(tlca_pkg::REG_ROOT_NODE, 1);
      send(tlca_pkg::KIND_QUERY, 1, 1);
      send(tlca_pkg::KIND_QUERY, 0, 1);
      send(tlca_pkg::KIND_QUERY, 1, 2);
      csr_write(tlca_pkg::REG_NODE_COUNT, 32'hFFFF_F800);
      send(tlca_pkg::KIND_QUERY, 1, 1);
      csr_write(tlca_pkg::REG_NODE_COUNT, 2047);
      send(tlca_pkg::KIND_QUERY, 1024, 1);
      send(tlca_pkg::KIND_QUERY, 2047, 5);
      send(tlca_pkg::KIND_EDGE, 1, 1024);
      send(tlca_pkg::KIND_QUERY, 3, 1024);
      // five node tree, one surplus edge, one bad edge
      csr_write(tlca_pkg::REG_NODE_COUNT, 5);
      send(tlca_pkg::KIND_CLEAR, 0, 0);
      send(tlca_pkg::KIND_EDGE, 1, 2);
      send(tlca_pkg::KIND_EDGE, 0, 3);
      send(tlca_pkg::KIND_EDGE, 3, 2);
      send(tlca_pkg::KIND_EDGE, 1, 4);
      send(tlca_pkg::KIND_QUERY, 3, 4);
      send(tlca_pkg::KIND_EDGE, 5, 4);
      send(tlca_pkg::KIND_EDGE, 2, 5);
      send(tlca_pkg::KIND_QUERY, 3, 5);
      send(tlca_pkg::KIND_NOP, 2047, 2047);
      send(tlca_pkg::KIND_QUERY, 2, 3);
      // shrink the count so edges to high ids are skipped by the walk
      csr_write(tlca_pkg::REG_NODE_COUNT, 3);
      send(tlca_pkg::KIND_QUERY, 3, 1);
      csr_write(tlca_pkg::REG_ROOT_NODE, 0);
      send(tlca_pkg::KIND_QUERY, 2, 3);
      csr_write(tlca_pkg::REG_ROOT_NODE, 2047);
      send(tlca_pkg::KIND_QUERY, 2, 3);
      // cycle leaves a node unreachable
      csr_write(tlca_pkg::REG_ROOT_NODE, 1);
      csr_write(tlca_pkg::REG_NODE_COUNT, 4);
      send(tlca_pkg::KIND_CLEAR, 0, 0);
      send(tlca_pkg::KIND_EDGE, 1, 2);
      send(tlca_pkg::KIND_EDGE, 2, 3);
      send(tlca_pkg::KIND_EDGE, 3, 1);
      send(tlca_pkg::KIND_QUERY, 1, 2);
   endtask

   // one random tree: load it, then query it
   task automatic tree_phase();
      int unsigned n;
      int unsigned cnt;
      int unsigned r;
      int unsigned t;
      int unsigned pa;
      int unsigned pb;
      int unsigned order[];
      r = $urandom_range(99);
      if (r < 70) n = $urandom_range(16, 2);
      else if (r < 92) n = $urandom_range(48, 17);
      else if (r < 96) n = 1;
      else n = $urandom_range(2047, 1000);
      cnt = (n > 1024) ? 1024 : n;
      csr_write(tlca_pkg::REG_NODE_COUNT,
                ($urandom_range(3) == 0) ? (n | ($urandom << 11)) : n);
      csr_write(tlca_pkg::REG_ROOT_NODE,
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(cnt, 1));
      send(tlca_pkg::KIND_CLEAR, $urandom_range(2047), $urandom_range(2047));
      if (cnt > 64) begin
         // too large to walk: only id and completeness checks
         repeat ($urandom_range(6))
            send(tlca_pkg::KIND_EDGE, pick_node(cnt), pick_node(cnt));
      end else begin
         order = new[cnt];
         for (int i = 0; i < cnt; i++) order[i] = i + 1;
         for (int i = cnt - 1; i > 0; i--) begin
            r = $urandom_range(i);
            t = order[i]; order[i] = order[r]; order[r] = t;
         end
         for (int i = 1; i < cnt; i++) begin
            pa = order[i];
            pb = order[$urandom_range(i - 1)];
            r = $urandom_range(99);
            if (r < 5)
               send(tlca_pkg::KIND_EDGE,
                    $urandom_range(1) ? 0 : $urandom_range(2047, cnt + 1), pb);
            if (r >= 95) pb = $urandom_range(cnt, 1);
            if (r == 50)
               send(tlca_pkg::KIND_NOP, $urandom_range(2047), $urandom_range(2047));
            if ($urandom_range(1)) send(tlca_pkg::KIND_EDGE, pa, pb);
            else send(tlca_pkg::KIND_EDGE, pb, pa);
         end
      end
      repeat ($urandom_range(20, 6)) begin
         r = $urandom_range(99);
         if (r < 3) send(tlca_pkg::KIND_CLEAR, 0, 0);
         else if (r < 6) send(tlca_pkg::KIND_EDGE, pick_node(cnt), pick_node(cnt));
         else if (r < 8)
            send(tlca_pkg::KIND_NOP, $urandom_range(2047), $urandom_range(2047));
         else send(tlca_pkg::KIND_QUERY, pick_node(cnt), pick_node(cnt));
      end
      // occasionally shrink the count under a loaded tree
      if (cnt > 2 && cnt <= 64 && $urandom_range(9) == 0) begin
         csr_write(tlca_pkg::REG_NODE_COUNT, $urandom_range(cnt - 1, 1));
         repeat (4) send(tlca_pkg::KIND_QUERY, pick_node(cnt), pick_node(cnt));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      items_sent  = 0;
      src_idle    = 0;
      dst_idle    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      while (items_sent < ITEM_GOAL) tree_phase();
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
